FILE: rtl/lss_pkg.sv
// Package for the literal substring search block.
// Holds widths, register codes, the configuration struct and byte helpers.
// No dependencies.
`default_nettype none

package lss_pkg;

  localparam int TEXT_W    = 8;
  localparam int POS_W     = 32;
  localparam int CNT_W     = 16;
  localparam int LEN_W     = 5;
  localparam int CFG_W     = 64;
  localparam int PADDR_W   = 6;
  localparam int REG_IDX_W = 3;
  localparam int PAT_BYTES = 16;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CASE_FOLD        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_BACKWARD  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OCCURRENCE_COUNT = 3'd5;

  localparam logic [TEXT_W-1:0] UPPER_A  = 8'h41;
  localparam logic [TEXT_W-1:0] UPPER_Z  = 8'h5A;
  localparam logic [TEXT_W-1:0] CASE_BIT = 8'h20;

  typedef struct packed {
    logic [CFG_W-1:0] pattern_low;
    logic [CFG_W-1:0] pattern_high;
    logic [LEN_W-1:0] pattern_length;
    logic             case_fold;
    logic             search_backward;
    logic [CNT_W-1:0] occurrence_count;
  } cfg_t;

  function automatic logic [TEXT_W-1:0] fold_byte(input logic [TEXT_W-1:0] c,
                                                  input logic fold);
    logic [TEXT_W-1:0] r;
    r = c;
    if (fold && c >= UPPER_A && c <= UPPER_Z) begin
      r = c | CASE_BIT;
    end
    return r;
  endfunction

  function automatic logic [TEXT_W-1:0] pattern_byte(input logic [CFG_W-1:0] lo,
                                                     input logic [CFG_W-1:0] hi,
                                                     input logic [3:0]       idx);
    logic [CFG_W-1:0] w;
    w = idx[3] ? hi : lo;
    return w[idx[2:0]*TEXT_W +: TEXT_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lss_in_if.sv
// Text channel of the literal substring search block.
// Carries one text word per handshake; uses lss_pkg for widths.
`default_nettype none

interface lss_in_if;
  import lss_pkg::*;

  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] text_byte;
  logic [POS_W-1:0]  position;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, text_byte, position, first_byte, last_byte,
                  input ready);
  modport sink (input valid, text_byte, position, first_byte, last_byte,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/lss_out_if.sv
// Result channel of the literal substring search block.
// Carries one result word per handshake; uses lss_pkg for widths.
`default_nettype none

interface lss_out_if;
  import lss_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [POS_W-1:0] match_begin;
  logic [POS_W-1:0] match_end;
  logic [CNT_W-1:0] occurrences;
  logic             found;
  logic             failed;

  modport source (output valid, hit, match_begin, match_end, occurrences, found,
                  failed, input ready);
  modport sink (input valid, hit, match_begin, match_end, occurrences, found,
                failed, output ready);
endinterface

`default_nettype wire

FILE: rtl/lss_apb.sv
// Configuration register file with an APB-style write/read port.
// Registers at byte address 8*i; depends on lss_pkg.
`default_nettype none

module lss_apb (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [lss_pkg::PADDR_W-1:0]  paddr,
  input  wire  [lss_pkg::CFG_W-1:0]    pwdata,
  output logic [lss_pkg::CFG_W-1:0]    prdata,
  output logic                         pready,
  output lss_pkg::cfg_t                cfg
);
  import lss_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[PADDR_W-1:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low      <= '0;
      cfg.pattern_high     <= '0;
      cfg.pattern_length   <= LEN_W'(1);
      cfg.case_fold        <= 1'b0;
      cfg.search_backward  <= 1'b0;
      cfg.occurrence_count <= CNT_W'(1);
    end else if (wr) begin
      case (idx)
        REG_PATTERN_LOW:      cfg.pattern_low      <= pwdata;
        REG_PATTERN_HIGH:     cfg.pattern_high     <= pwdata;
        REG_PATTERN_LENGTH:   cfg.pattern_length   <= pwdata[LEN_W-1:0];
        REG_CASE_FOLD:        cfg.case_fold        <= pwdata[0];
        REG_SEARCH_BACKWARD:  cfg.search_backward  <= pwdata[0];
        REG_OCCURRENCE_COUNT: cfg.occurrence_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_LOW:      prdata = cfg.pattern_low;
      REG_PATTERN_HIGH:     prdata = cfg.pattern_high;
      REG_PATTERN_LENGTH:   prdata = CFG_W'(cfg.pattern_length);
      REG_CASE_FOLD:        prdata = CFG_W'(cfg.case_fold);
      REG_SEARCH_BACKWARD:  prdata = CFG_W'(cfg.search_backward);
      REG_OCCURRENCE_COUNT: prdata = CFG_W'(cfg.occurrence_count);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lss_cell.sv
// One cell of the match chain: compares the text byte with its pattern byte
// and holds one partial-match bit. Depends on lss_pkg.
`default_nettype none

module lss_cell (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        load,
  input  wire                        clear,
  input  wire                        active,
  input  wire                        fold,
  input  wire                        carry,
  input  wire  [lss_pkg::TEXT_W-1:0] text,
  input  wire  [lss_pkg::TEXT_W-1:0] pattern,
  output logic                       match,
  output logic                       partial
);
  import lss_pkg::*;

  assign match = active & carry & (fold_byte(pattern, fold) == text);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= 1'b0;
    end else if (load) begin
      partial <= clear ? 1'b0 : match;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/literal_substring_search.sv
// Literal substring search: top level with the cell chain, counter and
// result register. Depends on lss_pkg, lss_in_if, lss_out_if, lss_apb, lss_cell.
//
// Unless the output stalls, the block takes one text word per clock and
// returns one result word per text word through a single output register;
// a new word is taken while the previous result is being taken. The rate
// is set by the cell chain: each cell compares the incoming byte with its
// pattern byte and registers its partial-match bit, which the next cell
// uses on the following word, so every cell checks one byte and, unless
// stalled, one word is taken every cycle for a pattern of up to MAX_PATTERN
// bytes. Write the configuration registers only while no word is in flight.
`default_nettype none

module literal_substring_search #(
  parameter int MAX_PATTERN = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  lss_in_if.sink                       text,
  lss_out_if.source                    result,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [lss_pkg::PADDR_W-1:0]  paddr,
  input  wire  [lss_pkg::CFG_W-1:0]    pwdata,
  output logic [lss_pkg::CFG_W-1:0]    prdata,
  output logic                         pready
);
  import lss_pkg::*;

  cfg_t cfg;

  logic [LEN_W-1:0]        len_eff;
  logic [CNT_W-1:0]        want;
  logic [TEXT_W-1:0]       text_folded;
  logic [MAX_PATTERN-1:0]  match;
  logic [MAX_PATTERN-1:0]  partial;
  logic [MAX_PATTERN-1:0]  carry;
  logic                    accept;
  logic                    step;
  logic                    hit_c;
  logic                    found_c;
  logic                    failed_c;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_base;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W-1:0]        cnt_next;
  logic                    done;
  logic                    done_next;
  logic [POS_W-1:0]        len_pos;
  logic [POS_W-1:0]        begin_c;
  logic [POS_W-1:0]        end_c;
  logic                    ovalid;

  lss_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    len_eff = cfg.pattern_length;
    if (len_eff == '0) begin
      len_eff = LEN_W'(1);
    end
    if (len_eff > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end
  end

  assign want        = (cfg.occurrence_count == '0) ? CNT_W'(1) : cfg.occurrence_count;
  assign text_folded = fold_byte(text.text_byte, cfg.case_fold);
  assign accept      = text.valid & text.ready;
  assign text.ready  = ~ovalid | result.ready;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W-1:0] back_idx;
    logic [LEN_W-1:0] sel_idx;

    assign back_idx = len_eff - LEN_W'(1) - LEN_W'(k);
    assign sel_idx  = cfg.search_backward ? back_idx : LEN_W'(k);

    if (k == 0) begin : g_head
      assign carry[k] = 1'b1;
    end else begin : g_link
      assign carry[k] = partial[k-1] & ~text.first_byte;
    end

    lss_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .load    (accept & step),
      .clear   (hit_c),
      .active  (LEN_W'(k) < len_eff),
      .fold    (cfg.case_fold),
      .carry   (carry[k]),
      .text    (text_folded),
      .pattern (pattern_byte(cfg.pattern_low, cfg.pattern_high, sel_idx[3:0])),
      .match   (match[k]),
      .partial (partial[k])
    );
  end

  always_comb begin
    hit_c = 1'b0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (len_eff == LEN_W'(k + 1)) begin
        hit_c = hit_c | match[k];
      end
    end
    step     = text.first_byte | ~done;
    hit_c    = hit_c & step;
    cnt_base = text.first_byte ? '0 : cnt;
    cnt_inc  = (cnt_base != '1) ? cnt_base + CNT_W'(1) : cnt_base;
    found_c  = hit_c & (cnt_inc == want);
    cnt_next = hit_c ? cnt_inc : cnt_base;
    failed_c = step & text.last_byte & ~found_c;
    done_next = step ? (found_c | text.last_byte) : 1'b1;
  end

  assign len_pos = POS_W'(len_eff);

  always_comb begin
    if (!hit_c) begin
      begin_c = '0;
      end_c   = '0;
    end else if (cfg.search_backward) begin
      begin_c = text.position;
      end_c   = text.position + len_pos;
    end else begin
      begin_c = text.position - len_pos + POS_W'(1);
      end_c   = text.position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt    <= cnt_next;
        done   <= done_next;
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.hit         <= hit_c;
      result.match_begin <= begin_c;
      result.match_end   <= end_c;
      result.occurrences <= cnt_next;
      result.found       <= found_c;
      result.failed      <= failed_c;
    end
  end

  assign result.valid = ovalid;

  a_found_is_hit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.found |-> result.hit)
    else $error("found without hit");

  a_found_failed_excl: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.found && result.failed))
    else $error("found and failed together");

  a_hit_clears_chain: assert property (@(posedge clk) disable iff (rst)
    accept && hit_c |=> partial == '0)
    else $error("partial matches survive a hit");

  a_hit_counts: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.hit |-> result.occurrences != '0)
    else $error("hit with zero occurrence count");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    accept && done && !text.first_byte |=> $stable(cnt) && $stable(partial))
    else $error("state changed after search finished");

endmodule

`default_nettype wire

FILE: test/lss_result_check.sv
`timescale 1ns / 100ps
// Result checker for the literal substring search block: snoops register
// writes and both word channels, predicts every result word and compares it.
// Depends on lss_pkg, lss_in_if and lss_out_if.

module lss_result_check (
  input  wire                        clk,
  input  wire                        rst,
  lss_in_if                          text,
  lss_out_if                         result,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire                        pready,
  input  wire [lss_pkg::PADDR_W-1:0] paddr,
  input  wire [lss_pkg::CFG_W-1:0]   pwdata,
  output int                         errors,
  output int                         pending
);
  import lss_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] match_begin;
    logic [POS_W-1:0] match_end;
    logic [CNT_W-1:0] occurrences;
    logic             found;
    logic             failed;
  } search_result_t;

  logic [2*CFG_W-1:0]   pattern_bits;
  logic [LEN_W-1:0]     length_reg;
  logic                 fold_on;
  logic                 backward_on;
  logic [CNT_W-1:0]     wanted_reg;

  logic [PAT_BYTES-1:0] partial;
  logic [CNT_W-1:0]     found_so_far;
  logic                 finished;

  search_result_t       results_due[$];

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [POS_W-1:0] got,
                             input logic [POS_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic logic [TEXT_W-1:0] to_lower(input logic [TEXT_W-1:0] c);
    if (fold_on && c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_BIT;
    end
    return c;
  endfunction

  function automatic search_result_t scan_text_byte(input logic [TEXT_W-1:0] c,
                                                    input logic [POS_W-1:0]  pos,
                                                    input logic              first,
                                                    input logic              last);
    search_result_t       r;
    int unsigned          len;
    int unsigned          idx;
    int unsigned          k;
    logic [CNT_W-1:0]     want;
    logic [PAT_BYTES-1:0] eq;
    logic [PAT_BYTES-1:0] next;
    logic [TEXT_W-1:0]    lc;
    r = '0;
    len = (length_reg == 0) ? 1 : (length_reg > PAT_BYTES) ? PAT_BYTES : length_reg;
    want = (wanted_reg == '0) ? CNT_W'(1) : wanted_reg;
    if (first) begin
      partial = '0;
      found_so_far = '0;
      finished = 1'b0;
    end
    if (!finished) begin
      lc = to_lower(c);
      eq = '0;
      for (k = 0; k < len; k++) begin
        idx = backward_on ? len - 1 - k : k;
        eq[k] = (to_lower(pattern_bits[idx*TEXT_W +: TEXT_W]) == lc);
      end
      next = {partial[PAT_BYTES-2:0], 1'b1} & eq;
      if (next[len-1]) begin
        r.hit = 1'b1;
        partial = '0;
        if (backward_on) begin
          r.match_begin = pos;
          r.match_end = pos + POS_W'(len);
        end else begin
          r.match_begin = pos - POS_W'(len) + POS_W'(1);
          r.match_end = pos + POS_W'(1);
        end
        if (found_so_far != '1) begin
          found_so_far++;
        end
        if (found_so_far == want) begin
          r.found = 1'b1;
          finished = 1'b1;
        end
      end else begin
        partial = next;
      end
      if (last) begin
        r.failed = !r.found;
        finished = 1'b1;
      end
    end
    r.occurrences = found_so_far;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    search_result_t want_word;
    if (rst) begin
      pattern_bits = '0;
      length_reg = 1;
      fold_on = 1'b0;
      backward_on = 1'b0;
      wanted_reg = 1;
      partial = '0;
      found_so_far = '0;
      finished = 1'b0;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1 -: REG_IDX_W])
          REG_PATTERN_LOW:      pattern_bits[CFG_W-1:0] = pwdata;
          REG_PATTERN_HIGH:     pattern_bits[2*CFG_W-1:CFG_W] = pwdata;
          REG_PATTERN_LENGTH:   length_reg = pwdata[LEN_W-1:0];
          REG_CASE_FOLD:        fold_on = pwdata[0];
          REG_SEARCH_BACKWARD:  backward_on = pwdata[0];
          REG_OCCURRENCE_COUNT: wanted_reg = pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want_word = results_due.pop_front();
          check_field("hit", result.hit, want_word.hit);
          check_field("match_begin", result.match_begin, want_word.match_begin);
          check_field("match_end", result.match_end, want_word.match_end);
          check_field("occurrences", result.occurrences, want_word.occurrences);
          check_field("found", result.found, want_word.found);
          check_field("failed", result.failed, want_word.failed);
        end
      end
      if (text.valid && text.ready) begin
        results_due.push_back(scan_text_byte(text.text_byte, text.position,
                                             text.first_byte, text.last_byte));
      end
    end
    pending <= results_due.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the literal substring search block: clock, reset, text
// words, result stalls and register writes, plus the verdict.
// Depends on lss_pkg, lss_in_if, lss_out_if, the RTL and lss_result_check.

module tb_top;
  import lss_pkg::*;

  localparam int               QUIET_LIMIT       = 2000;
  localparam int               WORDS_PER_SETTING = 96;
  localparam logic [POS_W-1:0] POS_MAX           = 32'hFFFF_FFFE;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [CFG_W-1:0]   pwdata;
  logic [CFG_W-1:0]   prdata;
  logic               pready;

  int                 errors;
  int                 pending;
  int                 quiet;
  int                 words_sent;
  int                 send_idle_pct;
  int                 stall_pct;

  logic [2*CFG_W-1:0] pat_bits;
  logic [LEN_W-1:0]   pat_len;
  logic               fold_on;
  logic               backward_on;

  lss_in_if  text_ch();
  lss_out_if result_ch();

  literal_substring_search dut (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lss_result_check result_check (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || psel || (text_ch.valid && text_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [TEXT_W-1:0] b, input logic [POS_W-1:0] pos,
                           input logic first, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid      <= 1'b1;
    text_ch.text_byte  <= b;
    text_ch.position   <= pos;
    text_ch.first_byte <= first;
    text_ch.last_byte  <= last;
    do @(posedge clk); while (!text_ch.ready);
    words_sent++;
  endtask

  task automatic settle();
    text_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                           input logic [LEN_W-1:0] len, input logic fold,
                           input logic back, input logic [CNT_W-1:0] occ);
    settle();
    pat_bits    = {hi, lo};
    pat_len     = len;
    fold_on     = fold;
    backward_on = back;
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, CFG_W'(len));
    write_reg(REG_CASE_FOLD, CFG_W'(fold));
    write_reg(REG_SEARCH_BACKWARD, CFG_W'(back));
    write_reg(REG_OCCURRENCE_COUNT, CFG_W'(occ));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [TEXT_W-1:0] flip_case(input logic [TEXT_W-1:0] b);
    logic [TEXT_W-1:0] up;
    up = b & ~CASE_BIT;
    if (up >= UPPER_A && up <= UPPER_Z && $urandom_range(1)) begin
      return b ^ CASE_BIT;
    end
    return b;
  endfunction

  function automatic logic [TEXT_W-1:0] filler_byte();
    logic [TEXT_W-1:0] b;
    int                k;
    case ($urandom_range(3))
      0: begin
        k = $urandom_range(PAT_BYTES - 1);
        b = pat_bits[k*TEXT_W +: TEXT_W];
      end
      1: b = TEXT_W'(UPPER_A + $urandom_range(1));
      2: begin
        b = $urandom_range(1) ? TEXT_W'(UPPER_A - 1) : TEXT_W'(UPPER_Z + 1);
        if ($urandom_range(1)) begin
          b = b + CASE_BIT;
        end
      end
      default: b = TEXT_W'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic run_search();
    int                n;
    int                i;
    int                k;
    int                len;
    int                cut;
    logic              closed;
    logic [POS_W-1:0]  pos;
    logic [TEXT_W-1:0] b;
    logic [TEXT_W-1:0] planted[$];
    len = (pat_len == 0) ? 1 : (pat_len > PAT_BYTES) ? PAT_BYTES : pat_len;
    n = $urandom_range(48, 1);
    closed = ($urandom_range(9) != 0);
    if ($urandom_range(9) == 0) begin
      pos = backward_on ? n - 1 : POS_MAX - (n - 1);
    end else if (backward_on) begin
      pos = $urandom_range(POS_MAX, n - 1);
    end else begin
      pos = $urandom_range(POS_MAX - (n - 1), 0);
    end
    for (i = 0; i < n; i++) begin
      if (planted.size() == 0 && $urandom_range(99) < 35) begin
        cut = ($urandom_range(6) == 0) ? $urandom_range(len, 1) : len;
        for (k = 0; k < cut; k++) begin
          planted.push_back(pat_bits[(backward_on ? len - 1 - k : k)*TEXT_W +: TEXT_W]);
        end
      end
      if (planted.size() != 0) begin
        b = planted.pop_front();
        if (fold_on || $urandom_range(9) == 0) begin
          b = flip_case(b);
        end
      end else begin
        b = flip_case(filler_byte());
      end
      send_word(b, pos, i == 0, closed && i == n - 1);
      pos = backward_on ? pos - 1 : pos + 1;
    end
  endtask

  task automatic noise_burst();
    int n;
    int i;
    n = $urandom_range(6, 1);
    for (i = 0; i < n; i++) begin
      send_word(TEXT_W'($urandom_range(255)), $urandom_range(POS_MAX, 0),
                $urandom_range(3) == 0, $urandom_range(3) == 0);
    end
  endtask

  task automatic random_setting();
    logic [2*CFG_W-1:0] bits;
    logic [LEN_W-1:0]   len;
    logic [CNT_W-1:0]   occ;
    int                 k;
    int                 roll;
    for (k = 0; k < PAT_BYTES; k++) begin
      roll = $urandom_range(3);
      if (roll < 2) begin
        bits[k*TEXT_W +: TEXT_W] = flip_case(TEXT_W'(UPPER_A + $urandom_range(1)));
      end else if (roll == 2) begin
        bits[k*TEXT_W +: TEXT_W] = flip_case(TEXT_W'(UPPER_A + $urandom_range(25)));
      end else begin
        bits[k*TEXT_W +: TEXT_W] = TEXT_W'($urandom_range(255));
      end
    end
    if ($urandom_range(9) == 0) begin
      bits = {$urandom, $urandom, $urandom, $urandom};
    end
    roll = $urandom_range(99);
    if (roll < 8) begin
      len = 0;
    end else if (roll < 16) begin
      len = LEN_W'($urandom_range(31, PAT_BYTES + 1));
    end else if (roll < 30) begin
      len = LEN_W'(PAT_BYTES);
    end else begin
      len = LEN_W'($urandom_range(PAT_BYTES - 1, 1));
    end
    roll = $urandom_range(99);
    if (roll < 8) begin
      occ = 0;
    end else if (roll < 12) begin
      occ = '1;
    end else if (roll < 60) begin
      occ = 1;
    end else begin
      occ = CNT_W'($urandom_range(6, 2));
    end
    configure(bits[CFG_W-1:0], bits[2*CFG_W-1:CFG_W], len,
              1'($urandom_range(1)), 1'($urandom_range(1)), occ);
  endtask

  task automatic random_phase(input int idle, input int stall);
    int s;
    int stop;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (s = 0; s < 3; s++) begin
      random_setting();
      stop = words_sent + WORDS_PER_SETTING;
      while (words_sent < stop) begin
        if ($urandom_range(99) < 85) begin
          run_search();
        end else begin
          noise_burst();
        end
      end
    end
  endtask

  initial begin : stimulus
    int i;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    text_ch.valid      = 1'b0;
    text_ch.text_byte  = '0;
    text_ch.position   = '0;
    text_ch.first_byte = 1'b0;
    text_ch.last_byte  = 1'b0;
    result_ch.ready    = 1'b0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    pat_bits           = '0;
    pat_len            = 1;
    fold_on            = 1'b0;
    backward_on        = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset pattern: a single zero byte
    send_word(8'h00, 32'd0, 1'b1, 1'b0);
    send_word(8'h00, 32'd1, 1'b0, 1'b0);
    send_word(8'h01, 32'd7, 1'b1, 1'b1);

    // non-overlapping hits up to the top position, found on the last word
    configure(64'h6161, '0, 5'd2, 1'b0, 1'b0, 16'd3);
    for (i = 0; i < 6; i++) begin
      send_word(8'h61, POS_MAX - 5 + i, i == 0, i == 5);
    end

    // oversized length, backward down to position zero
    configure('1, '1, 5'd31, 1'b1, 1'b1, 16'd1);
    for (i = 0; i < PAT_BYTES; i++) begin
      send_word(8'hFF, PAT_BYTES - 1 - i, i == 0, 1'b0);
    end

    // zero length and zero count, case folding around the letter range
    configure(64'h4241, '0, 5'd0, 1'b1, 1'b0, 16'd0);
    send_word(TEXT_W'(UPPER_Z + 1), 32'd100, 1'b1, 1'b0);
    send_word(TEXT_W'(UPPER_A - 1), 32'd101, 1'b0, 1'b0);
    send_word(UPPER_A | CASE_BIT, 32'd102, 1'b0, 1'b1);

    // highest requested count, never reached, fails on the last word
    configure(64'h78, '0, 5'd1, 1'b0, 1'b0, '1);
    for (i = 0; i < 12; i++) begin
      send_word(8'h78, POS_W'(i), i == 0, i == 11);
    end

    random_phase(0, 0);
    random_phase(80, 0);
    random_phase(0, 80);
    random_phase(25, 25);

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lss_pkg.sv
rtl/lss_in_if.sv
rtl/lss_out_if.sv
rtl/lss_apb.sv
rtl/lss_cell.sv
rtl/literal_substring_search.sv
test/lss_result_check.sv
test/tb_top.sv
